/* rtl/vrt_pkg.sv */
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int ORIGIN_FRACTION_BITS_DEF = 8;
  localparam int VOX_W       = 24;
  localparam int SQRT_STEPS  = 24;
  localparam int IN_DATA_W   = 160;
  localparam int OUT_DATA_W  = 80;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [1:0]  AXIS_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_QUERY = 2'd0,
    ST_HIT   = 2'd1,
    ST_MISS  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQI, S_SQRT, S_AXIS, S_MUL, S_DSI, S_DS, S_DBI, S_DB, S_FIN
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       sq_en;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       mul_en;
    logic       div_init;
    logic       div_sel;     // 0 spacing, 1 first boundary
    logic       div_step;
    logic       wr_sat;
    logic       wr_spacing;
    logic       wr_boundary;
    logic       out_load;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic axis_zero;
    logic out_free;
  } sts_t;

endpackage

/* rtl/vrt_ctrl.sv */
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: for a start item squares, root, then per axis multiply and two divisions;
// an answer item goes straight to the result state.
module vrt_ctrl #(
  parameter int ORIGIN_FRACTION_BITS = vrt_pkg::ORIGIN_FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  input  vrt_pkg::sts_t sts,
  output vrt_pkg::cmd_t cmd,
  output logic          in_ready
);

  localparam int NUM_W = ORIGIN_FRACTION_BITS + 33;
  localparam int CNT_W = $clog2(NUM_W + 1);

  vrt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrt_pkg::S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    case (state_r)
      vrt_pkg::S_IDLE: begin
        idx_nxt = '0;
        cnt_nxt = '0;
        if (in_valid) state_nxt = in_mode ? vrt_pkg::S_FIN : vrt_pkg::S_SQ;
      end
      vrt_pkg::S_SQ: begin
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = vrt_pkg::S_SQI;
        end else idx_nxt = idx_r + 2'd1;
      end
      vrt_pkg::S_SQI: begin
        cnt_nxt   = '0;
        state_nxt = vrt_pkg::S_SQRT;
      end
      vrt_pkg::S_SQRT: begin
        if (cnt_r == CNT_W'(vrt_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = vrt_pkg::S_AXIS;
        end else cnt_nxt = cnt_r + CNT_W'(1);
      end
      vrt_pkg::S_AXIS: begin
        if (sts.axis_zero) begin
          if (idx_r == 2'd2) state_nxt = vrt_pkg::S_FIN;
          else idx_nxt = idx_r + 2'd1;
        end else state_nxt = vrt_pkg::S_MUL;
      end
      vrt_pkg::S_MUL: state_nxt = vrt_pkg::S_DSI;
      vrt_pkg::S_DSI: begin
        cnt_nxt   = '0;
        state_nxt = vrt_pkg::S_DS;
      end
      vrt_pkg::S_DS: begin
        if (cnt_r == CNT_W'(NUM_W)) state_nxt = vrt_pkg::S_DBI;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      vrt_pkg::S_DBI: begin
        cnt_nxt   = '0;
        state_nxt = vrt_pkg::S_DB;
      end
      vrt_pkg::S_DB: begin
        if (cnt_r == CNT_W'(NUM_W)) begin
          if (idx_r == 2'd2) state_nxt = vrt_pkg::S_FIN;
          else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = vrt_pkg::S_AXIS;
          end
        end else cnt_nxt = cnt_r + CNT_W'(1);
      end
      vrt_pkg::S_FIN: begin
        if (sts.out_free) state_nxt = vrt_pkg::S_IDLE;
      end
      default: state_nxt = vrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.idx  = idx_r;
    in_ready = 1'b0;
    case (state_r)
      vrt_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      vrt_pkg::S_SQ:   cmd.sq_en     = 1'b1;
      vrt_pkg::S_SQI:  cmd.sqrt_init = 1'b1;
      vrt_pkg::S_SQRT: cmd.sqrt_step = 1'b1;
      vrt_pkg::S_AXIS: cmd.wr_sat    = sts.axis_zero;
      vrt_pkg::S_MUL:  cmd.mul_en    = 1'b1;
      vrt_pkg::S_DSI:  cmd.div_init  = 1'b1;
      vrt_pkg::S_DS: begin
        cmd.div_step   = (cnt_r != CNT_W'(NUM_W));
        cmd.wr_spacing = (cnt_r == CNT_W'(NUM_W));
      end
      vrt_pkg::S_DBI: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = 1'b1;
      end
      vrt_pkg::S_DB: begin
        cmd.div_step    = (cnt_r != CNT_W'(NUM_W));
        cmd.wr_boundary = (cnt_r == CNT_W'(NUM_W));
      end
      vrt_pkg::S_FIN: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result loaded into busy output");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");
  a_root_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vrt_pkg::S_SQRT) |-> (cnt_r < CNT_W'(vrt_pkg::SQRT_STEPS)))
    else $error("root step count overrun");

endmodule

/* rtl/vrt_dp.sv */
// ----------------------------------------------------------------------------
// vrt_dp
// Datapath: ray state, root and divide units, step logic, output register.
// ----------------------------------------------------------------------------
module vrt_dp #(
  parameter int ORIGIN_FRACTION_BITS = vrt_pkg::ORIGIN_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [vrt_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [1:0]                       in_user,
  input  vrt_pkg::cmd_t                    cmd,
  output vrt_pkg::sts_t                    sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [vrt_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [1:0]                       out_user
);

  localparam int F      = ORIGIN_FRACTION_BITS;
  localparam int NUM_W  = F + 33;
  localparam int DEN_W  = F + 16;
  localparam int PROD_W = F + 25;
  localparam logic [F:0] ONE_F = {1'b1, {F{1'b0}}};

  logic               mode_r, solid_r;
  logic signed [15:0] dir_r [3];
  logic [F-1:0]       frac_r [3];
  logic [15:0]        limit_r;
  logic [23:0]        vox_r [3];
  logic signed [1:0]  step_r [3];
  logic [31:0]        nb_r [3];
  logic [31:0]        sp_r [3];
  logic [1:0]         last_r;
  logic               active_r;
  logic [31:0]        acc_r;
  logic [47:0]        rad_r;
  logic [24:0]        srem_r;
  logic [23:0]        root_r;
  logic [F+24:0]      prod_r;
  logic [NUM_W-1:0]   dnum_r, quo_r;
  logic [DEN_W-1:0]   dden_r, drem_r;
  logic               out_valid_r;
  vrt_pkg::status_t   out_status_r;
  logic [23:0]        out_vox_r [3];
  logic signed [1:0]  out_nrm_r [3];

  // axis unit inputs
  logic signed [15:0] dsel;
  logic [15:0]        mag;
  logic [F:0]         fd;
  logic signed [31:0] sq;
  assign dsel = dir_r[cmd.idx];
  assign mag  = dsel[15] ? (~dsel + 16'd1) : dsel;
  assign fd   = dsel[15] ? {1'b0, frac_r[cmd.idx]} : (ONE_F - {1'b0, frac_r[cmd.idx]});
  assign sq   = 32'(dsel) * 32'(dsel);

  // root step: two radicand bits per cycle
  logic [26:0] st, strial;
  logic        sge;
  assign st     = {srem_r, rad_r[47:46]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sge    = (st >= strial);

  // divide step: one quotient bit per cycle
  logic [DEN_W:0] dt;
  logic           dge;
  logic [31:0]    qsat;
  assign dt   = {drem_r, dnum_r[NUM_W-1]};
  assign dge  = (dt >= {1'b0, dden_r});
  assign qsat = (|quo_r[NUM_W-1:32]) ? vrt_pkg::SAT32 : quo_r[31:0];

  // traversal step
  logic [1:0]  ax;
  logic [31:0] nb_sel;
  logic [32:0] nb_sum;
  logic [23:0] vox_new [3];
  logic        over;
  always_comb begin
    if (nb_r[0] < nb_r[1] && nb_r[0] < nb_r[2]) ax = 2'd0;
    else if (nb_r[1] < nb_r[2]) ax = 2'd1;
    else ax = 2'd2;
    nb_sel = nb_r[ax];
    nb_sum = {1'b0, nb_sel} + {1'b0, sp_r[ax]};
    for (int i = 0; i < 3; i++) begin
      vox_new[i] = (ax == 2'(i)) ? vox_r[i] + {{22{step_r[i][1]}}, step_r[i]} : vox_r[i];
    end
    over = (nb_sel > {8'd0, limit_r, 8'd0});
  end

  assign sts.axis_zero = (dsel == 16'sd0);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.load_in && !in_user[0]) active_r <= 1'b1;
      else if (cmd.out_load && mode_r && active_r && (solid_r || over)) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r  <= in_user[0];
      solid_r <= in_user[1];
      if (!in_user[0]) begin
        for (int i = 0; i < 3; i++) begin
          logic signed [31:0] o;
          logic signed [15:0] d;
          o = in_data[32*i +: 32];
          d = in_data[96 + 16*i +: 16];
          dir_r[i]  <= d;
          frac_r[i] <= o[F-1:0];
          vox_r[i]  <= 24'(o >>> F);
          step_r[i] <= (d == 16'sd0) ? 2'sd0 : (d[15] ? -2'sd1 : 2'sd1);
        end
        limit_r <= in_data[159:144];
        last_r  <= vrt_pkg::AXIS_NONE;
        acc_r   <= '0;
      end
    end
    if (cmd.sq_en) acc_r <= acc_r + 32'(unsigned'(sq));
    if (cmd.sqrt_init) begin
      rad_r  <= {acc_r, 16'd0};
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[45:0], 2'b00};
      if (sge) begin
        srem_r <= 25'(st - strial);
        root_r <= {root_r[22:0], 1'b1};
      end else begin
        srem_r <= st[24:0];
        root_r <= {root_r[22:0], 1'b0};
      end
    end
    if (cmd.mul_en) prod_r <= PROD_W'(fd) * PROD_W'(root_r);
    if (cmd.div_init) begin
      drem_r <= '0;
      quo_r  <= '0;
      if (cmd.div_sel) begin
        dnum_r <= {prod_r, 8'd0};
        dden_r <= DEN_W'({mag, {F{1'b0}}});
      end else begin
        dnum_r <= NUM_W'({root_r, 8'd0});
        dden_r <= DEN_W'(mag);
      end
    end
    if (cmd.div_step) begin
      dnum_r <= {dnum_r[NUM_W-2:0], 1'b0};
      quo_r  <= {quo_r[NUM_W-2:0], dge};
      drem_r <= dge ? DEN_W'(dt - {1'b0, dden_r}) : dt[DEN_W-1:0];
    end
    if (cmd.wr_sat) begin
      nb_r[cmd.idx] <= vrt_pkg::SAT32;
      sp_r[cmd.idx] <= vrt_pkg::SAT32;
    end
    if (cmd.wr_spacing)  sp_r[cmd.idx] <= qsat;
    if (cmd.wr_boundary) nb_r[cmd.idx] <= qsat;

    if (cmd.out_load) begin
      if (!mode_r) begin
        out_status_r <= vrt_pkg::ST_QUERY;
        for (int i = 0; i < 3; i++) begin
          out_vox_r[i] <= vox_r[i];
          out_nrm_r[i] <= '0;
        end
      end else if (!active_r) begin
        out_status_r <= vrt_pkg::ST_MISS;
        for (int i = 0; i < 3; i++) begin
          out_vox_r[i] <= '0;
          out_nrm_r[i] <= '0;
        end
      end else if (solid_r) begin
        out_status_r <= vrt_pkg::ST_HIT;
        for (int i = 0; i < 3; i++) begin
          out_vox_r[i] <= vox_r[i];
          out_nrm_r[i] <= (last_r == 2'(i)) ? -step_r[i] : 2'sd0;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          vox_r[i]     <= vox_new[i];
          out_vox_r[i] <= over ? 24'd0 : vox_new[i];
          out_nrm_r[i] <= '0;
        end
        nb_r[ax] <= nb_sum[32] ? vrt_pkg::SAT32 : nb_sum[31:0];
        last_r   <= ax;
        if (over) out_status_r <= vrt_pkg::ST_MISS;
        else out_status_r <= vrt_pkg::ST_QUERY;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_user  = out_status_r;
  assign out_data  = {2'b00, out_nrm_r[2], out_nrm_r[1], out_nrm_r[0],
                      out_vox_r[2], out_vox_r[1], out_vox_r[0]};

endmodule

/* rtl/voxel_ray_traversal_3d.sv */
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d
// Fixed-point grid walk of a ray; one result item per input item.
// ----------------------------------------------------------------------------
// Answer item: result loaded in one sequencer state (S_FIN), once the output is free.
// Start item: time set by the bit-serial root and the shared one-bit-per-cycle
//   divider, 6 divides; a zero direction component skips its multiply and divides.
// One item in flight; the next is taken once the result is in the output reg.
// Synchronous active-low reset clears the sequencer, ray-active and out valid.
module voxel_ray_traversal_3d #(
  parameter int ORIGIN_FRACTION_BITS = vrt_pkg::ORIGIN_FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, travel limit
  input  logic [vrt_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode, solid
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // voxel_x, voxel_y, voxel_z, normal_x, normal_y, normal_z, 2 pad
  output logic [vrt_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]                     out_tuser
);

  vrt_pkg::cmd_t cmd;
  vrt_pkg::sts_t sts;

  vrt_ctrl #(.ORIGIN_FRACTION_BITS(ORIGIN_FRACTION_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_mode(in_tuser[0]),
    .sts(sts), .cmd(cmd), .in_ready(in_tready)
  );

  vrt_dp #(.ORIGIN_FRACTION_BITS(ORIGIN_FRACTION_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_tdata), .in_user(in_tuser),
    .cmd(cmd), .sts(sts), .out_ready(out_tready), .out_valid(out_tvalid),
    .out_data(out_tdata), .out_user(out_tuser)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks voxel_ray_traversal_3d: start and answer items are driven with
// random gaps, results are taken with random stalls, and every result is
// compared field by field with an in-bench model of the grid walk.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = vrt_pkg::ORIGIN_FRACTION_BITS_DEF;
  localparam int MAX_CYCLES = 2_000_000;
  localparam int N_ITEMS = 450;
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ANSWER = 1'b1;

  typedef struct {
    vrt_pkg::status_t status;
    logic [23:0]      vox [3];
    logic [1:0]       nrm [3];
  } walk_result_t;

  class ray_scoreboard;
    logic [23:0]   voxel [3];
    int            step [3];
    logic [31:0]   bound [3];
    logic [31:0]   spacing [3];
    logic [31:0]   travel;
    logic [15:0]   limit;
    logic [1:0]    axis;
    bit            active;
    walk_result_t  pending [$];
    int            errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        voxel[i] = '0; step[i] = 0; bound[i] = vrt_pkg::SAT32; spacing[i] = vrt_pkg::SAT32;
      end
      travel = '0; limit = '0; axis = vrt_pkg::AXIS_NONE; active = 0; errors = 0;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic [31:0] sat(logic [63:0] q);
      return (q > 64'(vrt_pkg::SAT32)) ? vrt_pkg::SAT32 : q[31:0];
    endfunction

    function void emit(vrt_pkg::status_t st, bit with_vox, logic [1:0] nx, logic [1:0] ny,
                       logic [1:0] nz);
      walk_result_t r;
      r.status = st;
      for (int i = 0; i < 3; i++) r.vox[i] = with_vox ? voxel[i] : '0;
      r.nrm[0] = nx; r.nrm[1] = ny; r.nrm[2] = nz;
      pending.insert(pending.size(), r);
    endfunction

    function void note_input(logic [1:0] user, logic [vrt_pkg::IN_DATA_W-1:0] data);
      longint d [3];
      longint o, mag;
      logic [63:0] sum, len, fd, frac;
      int a;
      logic [1:0] n [3];
      if (user[0] == MODE_START) begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = longint'($signed(data[96 + 16*i +: 16]));
          sum += 64'(d[i] * d[i]);
        end
        len = int_sqrt(sum << 16);
        for (int i = 0; i < 3; i++) begin
          o = longint'($signed(data[32*i +: 32]));
          voxel[i] = 24'(o >>> FB);
          frac = 64'(data[32*i +: FB]);
          if (d[i] == 0) begin
            step[i] = 0; bound[i] = vrt_pkg::SAT32; spacing[i] = vrt_pkg::SAT32;
          end else begin
            mag = d[i] < 0 ? -d[i] : d[i];
            step[i] = d[i] > 0 ? 1 : -1;
            fd = d[i] > 0 ? (64'h1 << FB) - frac : frac;
            spacing[i] = sat((len << 8) / 64'(mag));
            bound[i] = sat(((fd * len) << 8) / (64'(mag) << FB));
          end
        end
        travel = '0;
        limit = data[159:144];
        axis = vrt_pkg::AXIS_NONE;
        active = 1;
        emit(vrt_pkg::ST_QUERY, 1, 2'b0, 2'b0, 2'b0);
      end else if (!active) begin
        emit(vrt_pkg::ST_MISS, 0, 2'b0, 2'b0, 2'b0);
      end else if (user[1]) begin
        for (int i = 0; i < 3; i++) n[i] = '0;
        if (axis != vrt_pkg::AXIS_NONE) n[axis] = 2'(-step[axis]);
        active = 0;
        emit(vrt_pkg::ST_HIT, 1, n[0], n[1], n[2]);
      end else begin
        // ties: x never wins one; a y-z tie goes to z
        if (bound[0] < bound[1] && bound[0] < bound[2]) a = 0;
        else if (bound[1] < bound[2]) a = 1;
        else a = 2;
        voxel[a] = voxel[a] + 24'(step[a]);
        travel = bound[a];
        bound[a] = sat(64'(bound[a]) + 64'(spacing[a]));
        axis = 2'(a);
        if (travel > {8'b0, limit, 8'b0}) begin
          active = 0;
          emit(vrt_pkg::ST_MISS, 0, 2'b0, 2'b0, 2'b0);
        end else begin
          emit(vrt_pkg::ST_QUERY, 1, 2'b0, 2'b0, 2'b0);
        end
      end
    endfunction

    function void check(logic [1:0] user, logic [vrt_pkg::OUT_DATA_W-1:0] data);
      walk_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h", $time, user, data);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (user != e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, user);
        errors++;
      end
      for (int i = 0; i < 3; i++) begin
        if (data[24*i +: 24] != e.vox[i]) begin
          $display("%0t: voxel[%0d] exp %h got %h", $time, i, e.vox[i], data[24*i +: 24]);
          errors++;
        end
        if (data[72 + 2*i +: 2] != e.nrm[i]) begin
          $display("%0t: normal[%0d] exp %b got %b", $time, i, e.nrm[i],
                   data[72 + 2*i +: 2]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [vrt_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [vrt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  ray_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;

  voxel_ray_traversal_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int draw_wait();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_item(logic mode, logic solid, logic [vrt_pkg::IN_DATA_W-1:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= data;
    in_tuser <= {solid, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input({solid, mode}, data);
    sent++;
  endtask

  task automatic send_start(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                            logic [15:0] maxd);
    send_item(MODE_START, 1'b0, {maxd, dz, dy, dx, oz, oy, ox});
  endtask

  task automatic send_answer(logic solid);
    logic [vrt_pkg::IN_DATA_W-1:0] junk;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
    send_item(MODE_ANSWER, solid, junk);
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'h0;
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_origin();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // result side: random stalls, with stretches of none
  always begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check(out_tuser, out_tdata);
    end
  end

  initial begin
    int steps;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // answers with no ray active
    send_answer(1'b0);
    send_answer(1'b1);
    // zero direction: query, then a miss
    send_start(32'h0000_0180, 32'hffff_ff80, 32'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send_answer(1'b0);
    // hit at start voxel has zero normal
    send_start(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ff00, 16'h8000, 16'h7fff,
               16'h8000, 16'h0);
    send_answer(1'b1);
    // zero limit: first step misses
    send_start(32'h80, 32'h80, 32'h80, 16'h4000, 16'h0, 16'h0, 16'h0);
    send_answer(1'b0);
    // equal components: ties step z, then y, then x
    send_start(32'h0, 32'h0, 32'h0, 16'h2000, 16'h2000, 16'h2000, 16'hffff);
    repeat (4) send_answer(1'b0);
    send_answer(1'b1);
    // negative axes, hit with normal
    send_start(32'hffff_fe40, 32'h10, 32'hff, 16'hc000, 16'hf000, 16'h0, 16'h0800);
    repeat (3) send_answer(1'b0);
    send_answer(1'b1);
    send_answer(1'b0);

    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_answer(1'($urandom));
      end else begin
        send_start(rand_origin(), rand_origin(), rand_origin(), rand_dir(), rand_dir(),
                   rand_dir(), ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 2048)));
        steps = $urandom_range(0, 12);
        repeat (steps) send_answer(1'b0);
        if ($urandom_range(0, 2) != 0) send_answer(1'b1);
      end
    end
    in_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

/* voxel_ray_traversal_3d.f */
rtl/vrt_pkg.sv
rtl/vrt_ctrl.sv
rtl/vrt_dp.sv
rtl/voxel_ray_traversal_3d.sv
tb/tb.sv
